FILE: rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ANY(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/tts_pkg.sv
package tts_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 40;
   localparam int LAT_BITS    = TIME_BITS + 1;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int TOL_W       = 20;
   localparam int INTV_W      = 24;
   localparam int CSR_IDX_W   = 8;
   localparam int REQ_DATA_W  = ((TIME_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_W = TIME_BITS + 2 * LAT_BITS;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(3000);
   localparam logic [INTV_W-1:0] INTV_RESET = INTV_W'(100000);

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL  = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      FUNC_SAMPLE   = 2'd0,
      FUNC_SCHEDULE = 2'd1,
      FUNC_ECHO     = 2'd2,
      FUNC_SESSION  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      KIND_FIRED    = 3'd0,
      KIND_SKIPPED  = 3'd1,
      KIND_PULSE    = 3'd2,
      KIND_SCHED    = 3'd3,
      KIND_REJECT   = 3'd4,
      KIND_MEASURED = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [LAT_BITS-1:0]    latency;
      logic [LAT_BITS-1:0]    lateness;
      logic [TIME_BITS-1:0]   rtime;
   } result_type;

endpackage

FILE: rtl/core/tts_ram.sv
module tts_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds its data when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/timed_trigger_scheduler.sv
// Timed trigger scheduler.
// Request channel (req_*): tuser carries func and session_stopped, tdata the
// event time. Response channel (rsp_*): tuser carries the result kind, tdata
// the result time, lateness and latency, tlast marks the final response of a
// request. Configuration (csr_*): index 0 tolerance, 1 measure interval;
// always ready; it is to be written only while the block is idle, which the block itself does not enforce.
// One request is worked at a time; req_tready is high only when idle.
// Schedule, echo: the response is held, then sent from the flush state as the
// final one, and the next request is accepted once the block is back in idle.
// Sample tick: a scan of the pending-time memory reads one entry per cycle;
// each due entry adds a fetch and a pop state, and a scan that finds nothing
// due ends the pops. Then the pulse check runs and the final response is sent.
// Session reports give no response and leave the block idle.
// Reset clears the queue count, latency, last pulse time, control state and
// configuration registers; the payload registers and pending-time memory are not cleared.
// A stalled receiver holds the response register; the block stops at its next
// response and resumes when rsp_tready returns.
module timed_trigger_scheduler
   import tts_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_W-1:0]     req_tdata,  // [39:0] event_time
   input  logic [2:0]                req_tuser,  // [1:0] func, [2] session_stopped
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_W-1:0]     rsp_tdata,  // [39:0] result_time,
                                                 // [80:40] lateness, [121:81] latency
   output logic [2:0]                rsp_tuser,  // [2:0] kind
   output logic                      rsp_tlast,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [INTV_W-1:0]         csr_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_FETCH = 6'b000100,
      ST_POP   = 6'b001000,
      ST_PULSE = 6'b010000,
      ST_FLUSH = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [LAT_BITS-1:0]  latency_ff, latency_in;
   logic [TIME_BITS-1:0] last_pulse_ff, last_pulse_in;
   logic                 prior_stop_ff, prior_stop_in;
   logic [TOL_W-1:0]     tol_ff;
   logic [INTV_W-1:0]    intv_ff;
   logic [TIME_BITS-1:0] t_ff, t_in;
   logic [LAT_BITS-1:0]  corr_ff, corr_in;
   logic [CNT_W-1:0]     scan_addr_ff, scan_addr_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [TIME_BITS-1:0] best_ff, best_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic                 have_best_ff, have_best_in;
   logic                 hold_valid_ff, hold_valid_in;
   result_type           hold_ff, hold_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff, rsp_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 ram_we, ram_re;
   logic [IDX_W-1:0]     ram_waddr, ram_raddr;
   logic [TIME_BITS-1:0] ram_wdata, ram_rdata;

   func_type             req_func;
   logic [TIME_BITS-1:0] req_time;
   logic                 req_stop;
   logic                 req_fire;
   logic                 out_free;
   logic [LAT_BITS:0]    corr_sum;
   logic [CNT_W-1:0]     count_dec;
   logic [LAT_BITS-1:0]  pulse_diff;
   logic                 pulse_due;
   logic                 better;
   logic [TIME_BITS-1:0] scan_min;
   logic [LAT_BITS-1:0]  late;
   logic [LAT_BITS-1:0]  echo_lat;

   assign req_func  = func_type'(req_tuser[1:0]);
   assign req_stop  = req_tuser[2];
   assign req_time  = req_tdata[TIME_BITS-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   // Corrected time: sample time plus signed latency, sign in the top bit
   assign corr_sum  = {2'b00, req_time} + {latency_ff[LAT_BITS-1], latency_ff};
   assign count_dec = count_ff - CNT_W'(1);
   assign pulse_diff = {1'b0, t_ff} - {1'b0, last_pulse_ff};
   assign pulse_due = (t_ff >= last_pulse_ff) &&
                      (pulse_diff >= LAT_BITS'(intv_ff));
   assign better    = !have_best_ff || (ram_rdata < best_ff);
   assign scan_min  = better ? ram_rdata : best_ff;
   assign late      = corr_ff - {1'b0, best_ff};
   assign echo_lat  = {1'b0, req_time} - {1'b0, last_pulse_ff};

   tts_ram #(
      .DEPTH(QUEUE_DEPTH),
      .WIDTH(TIME_BITS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // Sequencer: accept requests, scan for the minimum, pop, pulse, flush the held response
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      latency_in    = latency_ff;
      last_pulse_in = last_pulse_ff;
      prior_stop_in = prior_stop_ff;
      t_in          = t_ff;
      corr_in       = corr_ff;
      scan_addr_in  = scan_addr_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      have_best_in  = have_best_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = best_idx_ff;
      ram_wdata     = ram_rdata;
      ram_re        = 1'b0;
      ram_raddr     = scan_addr_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_func)
                  FUNC_SAMPLE: begin
                     t_in         = req_time;
                     corr_in      = corr_sum[LAT_BITS-1:0];
                     scan_addr_in = '0;
                     have_best_in = 1'b0;
                     if (corr_sum[LAT_BITS] || count_ff == '0) begin
                        state_in = ST_PULSE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_SCHEDULE: begin
                     hold_valid_in = 1'b1;
                     hold_in       = '{kind: KIND_SCHED, latency: latency_ff,
                                       lateness: '0, rtime: req_time};
                     if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                        hold_in.kind = KIND_REJECT;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = count_ff[IDX_W-1:0];
                        ram_wdata = req_time;
                        count_in  = count_ff + CNT_W'(1);
                     end
                     state_in = ST_FLUSH;
                  end
                  FUNC_ECHO: begin
                     latency_in    = echo_lat;
                     hold_valid_in = 1'b1;
                     hold_in       = '{kind: KIND_MEASURED, latency: echo_lat,
                                       lateness: '0, rtime: req_time};
                     state_in      = ST_FLUSH;
                  end
                  default: begin
                     if (req_stop && !prior_stop_ff) begin
                        latency_in    = '0;
                        last_pulse_in = '0;
                     end
                     prior_stop_in = req_stop;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // issue one read per cycle over the filled entries
            if (scan_addr_ff < count_ff) begin
               ram_re       = 1'b1;
               ram_raddr    = scan_addr_ff[IDX_W-1:0];
               scan_addr_in = scan_addr_ff + CNT_W'(1);
               rd_pend_in   = 1'b1;
               rd_idx_in    = scan_addr_ff[IDX_W-1:0];
            end
            if (rd_pend_ff) begin
               have_best_in = 1'b1;
               best_in      = scan_min;
               if (better) begin
                  best_idx_in = rd_idx_ff;
               end
               if ({1'b0, rd_idx_ff} == count_dec) begin
                  if ({1'b0, scan_min} <= corr_ff) begin
                     state_in = ST_FETCH;
                  end else begin
                     state_in = ST_PULSE;
                  end
               end
            end
         end
         ST_FETCH: begin
            // read the top entry to fill the hole left by the pop
            ram_re    = 1'b1;
            ram_raddr = count_dec[IDX_W-1:0];
            state_in  = ST_POP;
         end
         ST_POP: begin
            if (!hold_valid_ff || out_free) begin
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = hold_ff;
                  rsp_last_in  = 1'b0;
               end
               hold_valid_in = 1'b1;
               hold_in       = '{kind: KIND_FIRED, latency: latency_ff,
                                 lateness: late, rtime: best_ff};
               if (late > LAT_BITS'(tol_ff)) begin
                  hold_in.kind = KIND_SKIPPED;
               end
               ram_we       = 1'b1;
               ram_waddr    = best_idx_ff;
               ram_wdata    = ram_rdata;
               count_in     = count_dec;
               scan_addr_in = '0;
               have_best_in = 1'b0;
               state_in     = (count_dec == '0) ? ST_PULSE : ST_SCAN;
            end
         end
         ST_PULSE: begin
            if (!pulse_due) begin
               state_in = ST_FLUSH;
            end else if (!hold_valid_ff || out_free) begin
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = hold_ff;
                  rsp_last_in  = 1'b0;
               end
               hold_valid_in = 1'b1;
               hold_in       = '{kind: KIND_PULSE, latency: latency_ff,
                                 lateness: '0, rtime: t_ff};
               last_pulse_in = t_ff;
               state_in      = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // push the held response out as the final one
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = hold_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         latency_ff    <= '0;
         last_pulse_ff <= '0;
         prior_stop_ff <= 1'b0;
         rd_pend_ff    <= 1'b0;
         have_best_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         latency_ff    <= latency_in;
         last_pulse_ff <= last_pulse_in;
         prior_stop_ff <= prior_stop_in;
         rd_pend_ff    <= rd_pend_in;
         have_best_ff  <= have_best_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff  <= TOL_RESET;
         intv_ff <= INTV_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_TOLERANCE) begin
            tol_ff <= csr_data[TOL_W-1:0];
         end else if (csr_index == CSR_INTERVAL) begin
            intv_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      corr_ff      <= corr_in;
      scan_addr_ff <= scan_addr_in;
      rd_idx_ff    <= rd_idx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      hold_ff      <= hold_in;
      rsp_ff       <= rsp_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_ff.latency, rsp_ff.lateness, rsp_ff.rtime});

endmodule

FILE: rtl/core/tts_checker.sv
`include "assert_macros.svh"

module tts_checker
   import tts_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [2:0]            rsp_tuser,
   input logic                  rsp_tlast
);

   // hold a stalled response
   `ASSERT_CLK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // drop any response after reset
   `ASSERT_ANY(a_rsp_reset, reset |=> !rsp_tvalid, "response valid after reset")

   // single-response kinds always close their request
   `ASSERT_CLK(a_single_last, rsp_tvalid && (rsp_tuser == KIND_SCHED || rsp_tuser == KIND_REJECT || rsp_tuser == KIND_MEASURED) |-> rsp_tlast, "single response without tlast")

   // lateness is zero except for popped triggers
   `ASSERT_CLK(a_late_zero, rsp_tvalid && rsp_tuser != KIND_FIRED && rsp_tuser != KIND_SKIPPED |-> rsp_tdata[TIME_BITS+LAT_BITS-1:TIME_BITS] == '0, "nonzero lateness")

endmodule

bind timed_trigger_scheduler tts_checker u_tts_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);

FILE: tb/timed_trigger_scheduler_test.sv
module timed_trigger_scheduler_test
   import tts_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      kind_type            kind;
      logic [TIME_BITS-1:0] rtime;
      logic [LAT_BITS-1:0]  late;
      logic [LAT_BITS-1:0]  lat;
      logic                 last;
   } trig_rsp_type;

   typedef struct {
      func_type            func;
      logic [TIME_BITS-1:0] t;
      logic                 stop;
      int                   rep;
      bit                   typed;
      kind_type             kind;
      logic [LAT_BITS-1:0]  lat;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [2:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [2:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [INTV_W-1:0]      csr_data;

   // Scheduler shadow state
   logic [TIME_BITS-1:0] sh_times [QUEUE_DEPTH];
   int                   sh_count;
   logic [LAT_BITS-1:0]  sh_latency;
   logic [TIME_BITS-1:0] sh_last_pulse;
   logic                 sh_prior_stop;
   logic [TOL_W-1:0]     sh_tol;
   logic [INTV_W-1:0]    sh_intv;

   trig_rsp_type rsp_pending [$];
   int           errors;
   int           n_req;
   int           n_rsp;
   int           n_kind [6];
   bit           quiet;

   timed_trigger_scheduler uut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("timed_trigger_scheduler_test: errors");
      $finish;
   end

   task automatic add_rsp(kind_type k, logic [TIME_BITS-1:0] t, logic [LAT_BITS-1:0] l);
      trig_rsp_type r;
      r.kind  = k;
      r.rtime = t;
      r.late  = l;
      r.lat   = sh_latency;
      r.last  = 1'b0;
      rsp_pending.push_back(r);
   endtask

   // Work out the responses of one accepted request
   task automatic predict_trig(func_type f, logic [TIME_BITS-1:0] t, logic s);
      logic [LAT_BITS-1:0] mag;
      logic [LAT_BITS-1:0] corr;
      logic [LAT_BITS-1:0] late;
      logic                neg;
      int                  best;
      int                  n0;
      n0 = rsp_pending.size();
      case (f)
         FUNC_SAMPLE: begin
            neg = 1'b0;
            if (sh_latency[LAT_BITS-1]) begin
               mag = -sh_latency;
               if (mag > {1'b0, t}) neg = 1'b1;
               corr = neg ? '0 : {1'b0, t} - mag;
            end else begin
               corr = {1'b0, t} + sh_latency;
            end
            // pop due entries, earliest first
            while (!neg && sh_count > 0) begin
               best = 0;
               for (int i = 1; i < sh_count; i++)
                  if (sh_times[i] < sh_times[best]) best = i;
               if ({1'b0, sh_times[best]} > corr) break;
               late = corr - {1'b0, sh_times[best]};
               add_rsp(late <= sh_tol ? KIND_FIRED : KIND_SKIPPED, sh_times[best], late);
               sh_count--;
               sh_times[best] = sh_times[sh_count];
            end
            if (t >= sh_last_pulse && t - sh_last_pulse >= sh_intv) begin
               add_rsp(KIND_PULSE, t, '0);
               sh_last_pulse = t;
            end
         end
         FUNC_SCHEDULE: begin
            if (sh_count >= QUEUE_DEPTH) begin
               add_rsp(KIND_REJECT, t, '0);
            end else begin
               sh_times[sh_count] = t;
               sh_count++;
               add_rsp(KIND_SCHED, t, '0);
            end
         end
         FUNC_ECHO: begin
            sh_latency = {1'b0, t} - {1'b0, sh_last_pulse};
            add_rsp(KIND_MEASURED, t, '0);
         end
         default: begin
            if (s && !sh_prior_stop) begin
               sh_latency    = '0;
               sh_last_pulse = '0;
            end
            sh_prior_stop = s;
         end
      endcase
      if (rsp_pending.size() > n0) rsp_pending[rsp_pending.size()-1].last = 1'b1;
   endtask

   // Offer one request, hold until accepted, then idle for a drawn gap
   task automatic send_trig(func_type f, logic [TIME_BITS-1:0] t, logic s,
                            bit typed = 0,
                            trig_rsp_type want = '{kind: KIND_FIRED, default: '0});
      int g;
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      req_tuser  <= {s, f};
      do @(posedge clock); while (!req_tready);
      predict_trig(f, t, s);
      if (typed) begin
         void'(rsp_pending.pop_back());
         rsp_pending.push_back(want);
      end
      n_req++;
      g = quiet ? 0 : $urandom_range(0, 18);
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [INTV_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_TOLERANCE) sh_tol = val[TOL_W-1:0];
      else sh_intv = val;
      @(posedge clock);
   endtask

   // Let outstanding responses drain, then cover the session-report latency
   task automatic drain_rsp();
      int w;
      w = 0;
      req_tvalid <= 1'b0;
      while (rsp_pending.size() != 0 && w < 200000) begin
         @(posedge clock);
         w++;
      end
      repeat (60) @(posedge clock);
   endtask

   // Response side: random stall per response, check at each handshake
   initial begin
      trig_rsp_type e;
      int           g;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         g = quiet ? 0 : $urandom_range(0, 18);
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         n_rsp++;
         if (rsp_pending.size() == 0) begin
            $display("%t: response with none expected: kind %0d time %h", $time,
                     rsp_tuser, rsp_tdata[39:0]);
            errors++;
         end else begin
            e = rsp_pending.pop_front();
            if (e.kind <= KIND_MEASURED) n_kind[e.kind]++;
            if (rsp_tuser != e.kind || rsp_tdata[39:0] != e.rtime ||
                rsp_tdata[80:40] != e.late || rsp_tdata[121:81] != e.lat ||
                rsp_tlast != e.last) begin
               $display("%t: mismatch expected kind %0d time %h late %h lat %h last %b",
                        $time, e.kind, e.rtime, e.late, e.lat, e.last);
               $display("%t:          actual   kind %0d time %h late %h lat %h last %b",
                        $time, rsp_tuser, rsp_tdata[39:0], rsp_tdata[80:40],
                        rsp_tdata[121:81], rsp_tlast);
               errors++;
            end
         end
      end
   end

   initial begin
      stim_row_type         rows [$];
      trig_rsp_type         want;
      logic [TIME_BITS-1:0] now;
      logic [TIME_BITS-1:0] t;
      logic [TOL_W-1:0]     tol_set [6];
      logic [INTV_W-1:0]    intv_set [6];
      int                   r;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      errors = 0;
      n_req  = 0;
      n_rsp  = 0;
      quiet  = 0;
      foreach (n_kind[i]) n_kind[i] = 0;
      foreach (sh_times[i]) sh_times[i] = '0;
      sh_count      = 0;
      sh_latency    = '0;
      sh_last_pulse = '0;
      sh_prior_stop = 1'b0;
      sh_tol        = TOL_RESET;
      sh_intv       = INTV_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with reset register values
      rows = '{
         '{FUNC_SCHEDULE, 40'h0, 1'b0, 1, 1'b1, KIND_SCHED, 41'd0},
         '{FUNC_SCHEDULE, 40'hFF_FFFF_FFFF, 1'b0, 1, 1'b1, KIND_SCHED, 41'd0},
         '{FUNC_SAMPLE, 40'h0, 1'b0, 1, 1'b0, KIND_FIRED, 41'd0},
         '{FUNC_SCHEDULE, 40'd5000, 1'b0, 14, 1'b0, KIND_SCHED, 41'd0},
         '{FUNC_SCHEDULE, 40'd7000, 1'b1, 1, 1'b0, KIND_SCHED, 41'd0},
         '{FUNC_SCHEDULE, 40'd9000, 1'b0, 1, 1'b1, KIND_REJECT, 41'd0},
         '{FUNC_ECHO, 40'd1000, 1'b0, 1, 1'b1, KIND_MEASURED, 41'd1000},
         '{FUNC_SAMPLE, 40'd7500, 1'b0, 1, 1'b0, KIND_FIRED, 41'd0},
         '{FUNC_SAMPLE, 40'd200000, 1'b0, 1, 1'b0, KIND_FIRED, 41'd0},
         '{FUNC_ECHO, 40'd150000, 1'b0, 1, 1'b0, KIND_FIRED, 41'd0},
         '{FUNC_SCHEDULE, 40'd10, 1'b0, 1, 1'b0, KIND_SCHED, 41'd0},
         '{FUNC_SAMPLE, 40'd10, 1'b0, 1, 1'b0, KIND_FIRED, 41'd0},
         '{FUNC_SAMPLE, 40'd100, 1'b0, 1, 1'b0, KIND_FIRED, 41'd0},
         '{FUNC_SESSION, 40'h0, 1'b1, 1, 1'b0, KIND_FIRED, 41'd0},
         '{FUNC_SESSION, 40'h0, 1'b1, 1, 1'b0, KIND_FIRED, 41'd0},
         '{FUNC_SESSION, 40'hFF_FFFF_FFFF, 1'b0, 1, 1'b0, KIND_FIRED, 41'd0},
         '{FUNC_SAMPLE, 40'd50, 1'b0, 1, 1'b0, KIND_FIRED, 41'd0},
         '{FUNC_SAMPLE, 40'hFF_FFFF_FFFF, 1'b1, 1, 1'b0, KIND_FIRED, 41'd0},
         '{FUNC_ECHO, 40'hFF_FFFF_FFFF, 1'b0, 1, 1'b0, KIND_FIRED, 41'd0},
         '{FUNC_SAMPLE, 40'd0, 1'b0, 1, 1'b0, KIND_FIRED, 41'd0}
      };
      foreach (rows[i]) begin
         for (int k = 0; k < rows[i].rep; k++) begin
            want = '{rows[i].kind, rows[i].t, '0, rows[i].lat, 1'b1};
            send_trig(rows[i].func, rows[i].t, rows[i].stop, rows[i].typed, want);
         end
      end
      drain_rsp();

      // Random phases, register extremes included
      tol_set  = '{20'd0, 20'hFFFFF, 20'd3000, 20'd500, 20'd0, 20'd0};
      intv_set = '{24'd0, 24'hFFFFFF, 24'd1000, 24'd5000, 24'd0, 24'd0};
      tol_set[4]  = TOL_W'($urandom);
      intv_set[4] = INTV_W'($urandom_range(0, 20000));
      intv_set[5] = INTV_W'($urandom);
      now = 40'd1000;
      for (int p = 0; p < 6; p++) begin
         if (p == 1) write_csr(CSR_TOLERANCE, 24'hFFFFFF);
         else write_csr(CSR_TOLERANCE, {4'h0, tol_set[p]});
         write_csr(CSR_INTERVAL, intv_set[p]);
         quiet = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < 50; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
               t = ($urandom_range(0, 19) == 0) ? TIME_BITS'({$urandom, $urandom})
                                                : now + TIME_BITS'($urandom_range(0, 5000));
               send_trig(FUNC_SCHEDULE, t, 1'($urandom_range(0, 1)));
            end else if (r < 75) begin
               now = now + TIME_BITS'($urandom_range(0, 3000));
               t = ($urandom_range(0, 19) == 0) ? TIME_BITS'({$urandom, $urandom}) : now;
               send_trig(FUNC_SAMPLE, t, 1'($urandom_range(0, 1)));
            end else if (r < 88) begin
               t = ($urandom_range(0, 19) == 0)
                  ? TIME_BITS'({$urandom, $urandom})
                  : sh_last_pulse + TIME_BITS'($urandom_range(0, 4000));
               send_trig(FUNC_ECHO, t, 1'($urandom_range(0, 1)));
            end else begin
               send_trig(FUNC_SESSION, TIME_BITS'({$urandom, $urandom}),
                         1'($urandom_range(0, 1)));
            end
         end
         drain_rsp();
         quiet = 0;
      end

      if (rsp_pending.size() != 0) begin
         $display("%t: %0d expected responses never arrived", $time, rsp_pending.size());
         errors++;
      end
      $display("Sent %0d requests over six register settings, checked %0d responses",
               n_req, n_rsp);
      $display("fired %0d, skipped %0d, pulses %0d, scheduled %0d, rejected %0d, echoes %0d",
               n_kind[0], n_kind[1], n_kind[2], n_kind[3], n_kind[4], n_kind[5]);
      if (errors == 0) begin
         $display("timed_trigger_scheduler_test: clean");
      end else begin
         $display("timed_trigger_scheduler_test: errors");
      end
      $finish;
   end

endmodule
